/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed: implication");
// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

/* rtl/core/ttip_pkg.sv */
// ----------------------------------------------------------------------------
// ttip_pkg
// Types and constants of the streaming text-to-integer parser.
// ----------------------------------------------------------------------------
package ttip_pkg;

	// Saturation limit of the consumed-character count
	localparam logic [15:0] MAX_OFFSET = 16'd65535;

	// Radix register
	localparam int unsigned RADIX_W     = 5;
	localparam logic [4:0]  RADIX_RESET = 5'd10;
	localparam logic [4:0]  RADIX_HEX   = 5'd16;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'd32;
	localparam logic [7:0] HEX_BASE = 8'd10;

	// Parse phase codes
	localparam logic [1:0] PH_SPACES = 2'd0;
	localparam logic [1:0] PH_NUMBER = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	// One input character
	typedef struct packed {
		logic [7:0] ch;
		logic       first;
	} ttip_in_t;

	// One parse result
	typedef struct packed {
		logic signed [63:0] value;
		logic [15:0]        end_offset;
		logic               ended_on_nul;
	} ttip_out_t;

endpackage

/* rtl/core/text_to_integer_parser.sv */
// ----------------------------------------------------------------------------
// text_to_integer_parser
// Streaming parser: folds one character per transfer into a 64-bit value.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  in       | in_valid / in_ready    | in_data  (ch, first)
//  out      | out_valid / out_ready  | out_data (value, end_offset, ended_on_nul)
//  cfg      | cfg_we                 | cfg_wdata (radix)
//
//  One character per cycle sustained unless a finishing character meets a
//  stalled result; from the input register a character updates the parse
//  state and, at that same edge, loads its result, if any.
//  Reset puts the parser in the leading-space phase with radix 10.
//  A stalled result holds the input stage only when that stage would
//  produce another result; characters that yield no result keep flowing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_to_integer_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ttip_pkg::ttip_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ttip_pkg::ttip_out_t out_data,
	input  logic                cfg_we,
	input  logic [4:0]          cfg_wdata
);

	logic [4:0]          radix_q;
	logic                valid_s1;
	ttip_pkg::ttip_in_t  data_s1;
	logic [1:0]          phase_q;
	logic                neg_q;
	logic [63:0]         acc_q;
	logic [15:0]         cons_q;
	logic                out_valid_q;
	ttip_pkg::ttip_out_t out_data_q;

	logic [1:0]  phase_d;
	logic        neg_d;
	logic [63:0] acc_d;
	logic [15:0] cons_d;
	logic        emit;
	logic        go_s1;
	logic [63:0] prod;

	// Radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= ttip_pkg::RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// Stage 1 advances unless it makes a result that cannot be stored
	assign go_s1    = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// Parse step: next state and result for the character in stage 1
	always_comb begin
		logic [1:0]  ph;
		logic        neg;
		logic [63:0] acc;
		logic [15:0] cons;
		logic [15:0] cons_inc;
		logic [7:0]  ch;
		logic [7:0]  up;
		logic        hex;
		logic        num_path;
		logic        is_dec;
		logic        is_hexl;
		logic [3:0]  digit;

		ch   = data_s1.ch;
		ph   = data_s1.first ? ttip_pkg::PH_SPACES : phase_q;
		neg  = data_s1.first ? 1'b0 : neg_q;
		acc  = data_s1.first ? 64'd0 : acc_q;
		cons = data_s1.first ? 16'd0 : cons_q;
		cons_inc = (cons < ttip_pkg::MAX_OFFSET) ? cons + 16'd1 : cons;
		up  = (ch >= ttip_pkg::CH_LA && ch <= ttip_pkg::CH_LZ) ? ch - ttip_pkg::CASE_GAP : ch;
		hex = (radix_q == ttip_pkg::RADIX_HEX);
		is_dec  = (ch >= ttip_pkg::CH_0 && ch <= ttip_pkg::CH_9);
		is_hexl = hex && (up >= ttip_pkg::CH_UA && up <= ttip_pkg::CH_UF);
		digit = is_dec ? ch[3:0] : 4'(up - ttip_pkg::CH_UA + ttip_pkg::HEX_BASE);
		prod  = acc * 64'(radix_q);

		phase_d  = ph;
		neg_d    = neg;
		acc_d    = acc;
		cons_d   = cons;
		emit     = 1'b0;
		num_path = 1'b0;

		case (ph)
			ttip_pkg::PH_SPACES: begin
				if (ch == ttip_pkg::CH_SPACE) begin
					cons_d = cons_inc;
				end else begin
					phase_d = ttip_pkg::PH_NUMBER;
					if (ch == ttip_pkg::CH_MINUS) begin
						neg_d  = 1'b1;
						cons_d = cons_inc;
					end else begin
						num_path = 1'b1;
					end
				end
			end
			ttip_pkg::PH_NUMBER: begin
				num_path = 1'b1;
			end
			default: begin
			end
		endcase

		// Fold a digit, skip an X in base 16, or end the parse
		if (num_path) begin
			if (hex && up == ttip_pkg::CH_UX) begin
				cons_d = cons_inc;
			end else if (is_dec || is_hexl) begin
				acc_d  = prod + 64'(digit);
				cons_d = cons_inc;
			end else begin
				emit    = 1'b1;
				phase_d = ttip_pkg::PH_DONE;
			end
		end
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ttip_pkg::PH_SPACES;
			neg_q   <= 1'b0;
			acc_q   <= 64'd0;
			cons_q  <= 16'd0;
		end else if (go_s1) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			acc_q   <= acc_d;
			cons_q  <= cons_d;
		end
	end

	// Result register: load on a finishing character, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit) begin
			out_data_q.value        <= $signed(neg_d ? 64'd0 - acc_d : acc_d);
			out_data_q.end_offset   <= cons_d;
			out_data_q.ended_on_nul <= (data_s1.ch == ttip_pkg::CH_NUL);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Checks
	`ASSERT_NEXT(a_emit_done, clk, arst_n, go_s1 && emit, phase_q == ttip_pkg::PH_DONE)
	`ASSERT_IMPLIES(a_done_quiet, clk, arst_n, valid_s1 && !data_s1.first && phase_q == ttip_pkg::PH_DONE, !emit)
	`ASSERT_IMPLIES(a_stall_hold, clk, arst_n, valid_s1 && emit && out_valid_q && !out_ready, !in_ready)
	`ASSERT_NEXT(a_load_valid, clk, arst_n, go_s1 && emit, out_valid_q)

endmodule
